FILE: hw/rtl/positional_list_store_assert.svh
// Assertion macros for the list store RTL.
`ifndef POSITIONAL_LIST_STORE_ASSERT_SVH
`define POSITIONAL_LIST_STORE_ASSERT_SVH
`ifndef SYNTHESIS
`define PLS_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("list store check failed");
`define PLS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("list store check failed");
`else
`define PLS_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define PLS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: hw/rtl/pls_pkg.sv
// Types and codes for the positional list store.
package pls_pkg;

  localparam logic [1:0] CMD_INSERT  = 2'd0;
  localparam logic [1:0] CMD_DELETE  = 2'd1;
  localparam logic [1:0] CMD_DISPLAY = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_POS = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_DELETE,
    OP_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t   op;
    logic [7:0] sel;
  } cell_ctl_t;

endpackage

FILE: hw/rtl/pls_cell.sv
// One storage cell of the list chain.
module pls_cell #(
  parameter int INDEX = 0
) (
  input  logic              clk,
  input  pls_pkg::cell_ctl_t ctl,
  input  logic [31:0]       left,
  input  logic [31:0]       right,
  input  logic [31:0]       head,
  input  logic [31:0]       din,
  output logic [31:0]       q
);

  logic [7:0]  idx;
  logic [31:0] q_next;

  assign idx = 8'(INDEX);

  always_comb begin
    q_next = q;
    case (ctl.op)
      pls_pkg::OP_INSERT: begin
        if (idx > ctl.sel) begin
          q_next = left;
        end else if (idx == ctl.sel) begin
          q_next = din;
        end
      end
      pls_pkg::OP_DELETE: begin
        if (idx >= ctl.sel) begin
          q_next = right;
        end
      end
      pls_pkg::OP_ROTATE: begin
        if (idx < ctl.sel) begin
          q_next = right;
        end else if (idx == ctl.sel) begin
          q_next = head;
        end
      end
      default: q_next = q;
    endcase
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

FILE: hw/rtl/positional_list_store.sv
// Positional list store: insert, delete and display over a chain of cells.
// Insert and delete update the list on acceptance; the status transfer appears the cycle after acceptance.
// Outside a display, a command is accepted whenever the output register is empty or draining.
// Display holds off the input until its last entry is loaded out (an empty list gives one EMPTY status).
// On acceptance the state moves to S_DISP, which then registers the first entry out; m_tready paces the rest.
// Synchronous reset empties the list and the output; cell contents are not cleared.
`include "positional_list_store_assert.svh"
module positional_list_store #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // cmd[1:0], position[9:2], value[41:10], zero fill
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // entry_value[31:0]
  output logic [1:0]  m_tuser,   // status[1:0]
  output logic        m_tlast
);

  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic {
    S_IDLE,
    S_DISP
  } state_t;

  state_t             state;
  logic [CW-1:0]      count;
  logic [CW-1:0]      remaining;
  logic [1:0]         cmd;
  logic [7:0]         position;
  logic [31:0]        value;
  logic               s_fire;
  logic               out_free;
  logic               out_load;
  logic [8:0]         pos9;
  logic [8:0]         cnt9;
  logic               ins_bad;
  logic               ins_full;
  logic               ins_ok;
  logic               del_empty;
  logic               del_bad;
  logic               del_ok;
  pls_pkg::cell_ctl_t ctl;
  logic [31:0]        cell_q [CAPACITY];

  assign cmd      = s_tdata[1:0];
  assign position = s_tdata[9:2];
  assign value    = s_tdata[41:10];

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE) && out_free;
  assign s_fire   = s_tvalid && s_tready;

  assign out_load = (state == S_DISP) ? out_free :
                    (s_fire && ((cmd inside {pls_pkg::CMD_INSERT, pls_pkg::CMD_DELETE}) ||
                                (cmd == pls_pkg::CMD_DISPLAY && del_empty)));

  assign pos9      = {1'b0, position};
  assign cnt9      = 9'(count);
  assign ins_bad   = (position == 8'd0) || (pos9 > cnt9 + 9'd1);
  assign ins_full  = cnt9 == 9'(CAPACITY);
  assign ins_ok    = !ins_bad && !ins_full;
  assign del_empty = count == '0;
  assign del_bad   = (position == 8'd0) || (pos9 > cnt9);
  assign del_ok    = !del_empty && !del_bad;

  always_comb begin
    ctl.op  = pls_pkg::OP_HOLD;
    ctl.sel = position - 8'd1;
    if (state == S_DISP) begin
      ctl.sel = 8'(count) - 8'd1;
      if (out_free) begin
        ctl.op = pls_pkg::OP_ROTATE;
      end
    end else if (s_fire) begin
      if (cmd == pls_pkg::CMD_INSERT && ins_ok) begin
        ctl.op = pls_pkg::OP_INSERT;
      end else if (cmd == pls_pkg::CMD_DELETE && del_ok) begin
        ctl.op = pls_pkg::OP_DELETE;
      end
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [31:0] left;
    logic [31:0] right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_final
      assign right = '0;
    end else begin : g_mid_r
      assign right = cell_q[i+1];
    end
    pls_cell #(
      .INDEX(i)
    ) u_cell (
      .clk  (clk),
      .ctl  (ctl),
      .left (left),
      .right(right),
      .head (cell_q[0]),
      .din  (value),
      .q    (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      remaining <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !out_load) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_fire) begin
            case (cmd)
              pls_pkg::CMD_INSERT: begin
                m_tvalid <= 1'b1;
                m_tdata  <= '0;
                m_tlast  <= 1'b1;
                if (ins_bad) begin
                  m_tuser <= pls_pkg::ST_BAD_POS;
                end else if (ins_full) begin
                  m_tuser <= pls_pkg::ST_FULL;
                end else begin
                  m_tuser <= pls_pkg::ST_OK;
                  count   <= count + CW'(1);
                end
              end
              pls_pkg::CMD_DELETE: begin
                m_tvalid <= 1'b1;
                m_tdata  <= '0;
                m_tlast  <= 1'b1;
                if (del_empty) begin
                  m_tuser <= pls_pkg::ST_EMPTY;
                end else if (del_bad) begin
                  m_tuser <= pls_pkg::ST_BAD_POS;
                end else begin
                  m_tuser <= pls_pkg::ST_OK;
                  count   <= count - CW'(1);
                end
              end
              pls_pkg::CMD_DISPLAY: begin
                if (del_empty) begin
                  m_tvalid <= 1'b1;
                  m_tdata  <= '0;
                  m_tlast  <= 1'b1;
                  m_tuser  <= pls_pkg::ST_EMPTY;
                end else begin
                  state     <= S_DISP;
                  remaining <= count;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_DISP: begin
          if (out_free) begin
            m_tvalid  <= 1'b1;
            m_tdata   <= cell_q[0];
            m_tuser   <= pls_pkg::ST_OK;
            m_tlast   <= remaining == CW'(1);
            remaining <= remaining - CW'(1);
            if (remaining == CW'(1)) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `PLS_ASSERT_IMPLIES(a_count_bound, clk, rst, 1'b1, 32'(count) <= CAPACITY)
  `PLS_ASSERT_NEXT(a_insert_grows, clk, rst, s_fire && cmd == pls_pkg::CMD_INSERT && ins_ok, count == $past(count) + CW'(1))
  `PLS_ASSERT_NEXT(a_delete_shrinks, clk, rst, s_fire && cmd == pls_pkg::CMD_DELETE && del_ok, count == $past(count) - CW'(1))
  `PLS_ASSERT_NEXT(a_disp_ends, clk, rst, state == S_DISP && out_free && remaining == CW'(1), state == S_IDLE && m_tlast)

endmodule
